// ===== hdl/sdf_pkg.sv =====
// Shared types, constants and saturating Q16.16 helpers for the smooth damp follower.
`timescale 1ns / 1ps

package sdf_pkg;

   typedef logic signed [31:0] word_type;
   typedef logic [16:0]        dtime_type;
   typedef logic [30:0]        ureg_type;
   typedef logic [0:0]         regidx_type;

   localparam regidx_type REG_SMOOTH_TIME = 1'b0;
   localparam regidx_type REG_SPEED_CAP   = 1'b1;

   localparam ureg_type SMOOTH_TIME_RESET = 31'd65536;
   localparam ureg_type SPEED_UNLIMITED   = 31'h7FFF_FFFF;
   localparam ureg_type ST_MIN            = 31'd7;

   localparam logic [14:0] C_048  = 15'd31457;
   localparam logic [14:0] C_0235 = 15'd15401;

   // quotient bits produced by the divider
   localparam int DIV_STEPS = 34;

   function automatic word_type sat66(input logic signed [65:0] v);
      if (v > 66'sd2147483647) begin
         return 32'sh7FFF_FFFF;
      end else if (v < -66'sd2147483648) begin
         return 32'sh8000_0000;
      end
      return v[31:0];
   endfunction

   function automatic word_type add_sat(input word_type a, input word_type b);
      return sat66(66'(a) + 66'(b));
   endfunction

   function automatic word_type sub_sat(input word_type a, input word_type b);
      return sat66(66'(a) - 66'(b));
   endfunction

   // Q16.16 product, truncated toward zero, then saturated
   function automatic word_type mul_q16(input logic signed [65:0] p);
      logic signed [65:0] r;
      r = (p + (p[65] ? 66'sd65535 : 66'sd0)) >>> 16;
      return sat66(r);
   endfunction

endpackage

// ===== hdl/sdf_channels.sv =====
// Request and response channel interfaces of the smooth damp follower.
`timescale 1ns / 1ps

interface sdf_req_if;
   import sdf_pkg::*;
   logic      valid;
   logic      ready;
   word_type  current_x;
   word_type  current_y;
   word_type  target_x;
   word_type  target_y;
   dtime_type step_time;

   modport source (output valid, current_x, current_y, target_x, target_y, step_time,
                   input ready);
   modport sink (input valid, current_x, current_y, target_x, target_y, step_time,
                 output ready);
endinterface

interface sdf_rsp_if;
   import sdf_pkg::*;
   logic     valid;
   logic     ready;
   word_type next_x;
   word_type next_y;
   word_type speed_x;
   word_type speed_y;
   logic     snapped;

   modport source (output valid, next_x, next_y, speed_x, speed_y, snapped, input ready);
   modport sink (input valid, next_x, next_y, speed_x, speed_y, snapped, output ready);
endinterface

// ===== hdl/sdf_div.sv =====
// Iterative restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps

module sdf_div (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [63:0] num,
   input  logic [32:0] den,
   output logic [33:0] quo,
   output logic        done
);
   import sdf_pkg::*;

   logic [32:0] rem_ff;
   logic [33:0] quo_ff;
   logic [32:0] den_ff;
   logic [5:0]  count_ff;
   logic        busy_ff;
   logic        done_ff;
   logic [33:0] trial;
   logic        fits;

   assign trial = {rem_ff, quo_ff[33]};
   assign fits  = trial >= {1'b0, den_ff};
   assign quo   = quo_ff;
   assign done  = done_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            rem_ff   <= {3'b000, num[63:34]};
            quo_ff   <= num[33:0];
            den_ff   <= den;
            count_ff <= 6'(DIV_STEPS - 1);
            busy_ff  <= 1'b1;
         end else if (busy_ff) begin
            rem_ff <= fits ? 33'(trial - {1'b0, den_ff}) : trial[32:0];
            quo_ff <= {quo_ff[32:0], fits};
            if (count_ff == '0) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end else begin
               count_ff <= count_ff - 6'd1;
            end
         end
      end
   end

endmodule

// ===== hdl/sdf_sqrt.sv =====
// Iterative integer square root, two radicand bits per cycle.
`timescale 1ns / 1ps

module sdf_sqrt (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [63:0] radicand,
   output logic [31:0] root,
   output logic        done
);
   logic [63:0] n_ff;
   logic [63:0] res_ff;
   logic [63:0] bit_ff;
   logic        busy_ff;
   logic        done_ff;
   logic [63:0] trial;

   assign trial = res_ff + bit_ff;
   assign root  = res_ff[31:0];
   assign done  = done_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            n_ff    <= radicand;
            res_ff  <= '0;
            bit_ff  <= 64'h4000_0000_0000_0000;
            busy_ff <= 1'b1;
         end else if (busy_ff) begin
            if (n_ff >= trial) begin
               n_ff   <= n_ff - trial;
               res_ff <= (res_ff >> 1) + bit_ff;
            end else begin
               res_ff <= res_ff >> 1;
            end
            bit_ff <= bit_ff >> 2;
            if (bit_ff[0]) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

endmodule

// ===== hdl/vector2_smooth_damp_follower.sv =====
// Smooth damp follower: critically damped 2D spring toward a target, Q16.16.
// One request at a time. The shared divider computes omega, the decay term
// (skipped when the decay term is zero) and, when the speed cap clips the
// offset, the two rescales; clipping also runs the square root. Every product
// goes through one shared multiplier. A result still waiting for the receiver
// holds the next request at its final step. Ready is high only while idle; the
// result register frees the input side as soon as the result is loaded.
`timescale 1ns / 1ps

module vector2_smooth_damp_follower (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_we,
   input  sdf_pkg::regidx_type  csr_index,
   input  sdf_pkg::ureg_type    csr_wdata,
   sdf_req_if.sink              req_ch,
   sdf_rsp_if.source            rsp_ch
);
   import sdf_pkg::*;

   typedef enum logic [5:0] {
      S_IDLE, S_W_OM, S_X_I, S_X_C, S_X2_I, S_X2_C, S_X3_I, S_X3_C, S_T2_C, S_T3H_C,
      S_T3L_C, S_W_E, S_CH, S_MC_C, S_SQX_C, S_SQY_C, S_CMP, S_W_SQ, S_SCX_D, S_W_SCX,
      S_SCY_D, S_W_SCY, S_TT, S_A_X, S_A_Y, S_TM_X, S_TM_Y, S_B_X, S_B_Y, S_V_X, S_V_Y,
      S_O_X, S_O_Y, S_D1, S_D2, S_DONE
   } state_type;

   state_type state_ff;

   ureg_type  smooth_time_ff, speed_cap_ff, st_ff, om_ff, mc_ff;
   word_type  vel_x_ff, vel_y_ff;
   word_type  cx_ff, cy_ff, tx_ff, ty_ff;
   dtime_type dt_ff;
   logic [22:0] x_ff;
   logic        ez_ff;
   logic [29:0] x2_ff;
   logic [36:0] x3_ff;
   logic [28:0] t2_ff;
   logic [34:0] t3h_ff;
   logic [16:0] e_ff;
   word_type  chx_ff, chy_ff, ttx_ff, tty_ff, ax_ff, ay_ff, tmx_ff, tmy_ff;
   word_type  bx_ff, by_ff, vx_ff, vy_ff, ox_ff, oy_ff;
   logic [63:0] sq_ff;
   logic [31:0] g_ff;
   logic signed [65:0] prod_ff;
   logic signed [65:0] dot1_ff;
   logic        snap_ff;

   logic        rsp_valid_ff;
   word_type    next_x_ff, next_y_ff, speed_x_ff, speed_y_ff;
   logic        snapped_ff;

   logic        div_start_ff;
   logic [63:0] div_num_ff;
   logic [32:0] div_den_ff;
   logic [33:0] div_quo;
   logic        div_done;
   logic        sqrt_start_ff;
   logic [31:0] sqrt_root;
   logic        sqrt_done;

   logic signed [32:0] mul_a, mul_b;
   logic signed [32:0] abs_chx, abs_chy;
   logic [36:0]        d_sum;
   logic signed [66:0] dot_sum;
   ureg_type           st_in;

   sdf_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start_ff),
      .num   (div_num_ff),
      .den   (div_den_ff),
      .quo   (div_quo),
      .done  (div_done)
   );

   sdf_sqrt u_sqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (sqrt_start_ff),
      .radicand (sq_ff),
      .root     (sqrt_root),
      .done     (sqrt_done)
   );

   assign req_ch.ready   = (state_ff == S_IDLE);
   assign rsp_ch.valid   = rsp_valid_ff;
   assign rsp_ch.next_x  = next_x_ff;
   assign rsp_ch.next_y  = next_y_ff;
   assign rsp_ch.speed_x = speed_x_ff;
   assign rsp_ch.speed_y = speed_y_ff;
   assign rsp_ch.snapped = snapped_ff;

   assign st_in   = (smooth_time_ff < ST_MIN) ? ST_MIN : smooth_time_ff;
   assign abs_chx = chx_ff[31] ? -33'(chx_ff) : 33'(chx_ff);
   assign abs_chy = chy_ff[31] ? -33'(chy_ff) : 33'(chy_ff);
   assign d_sum   = 37'd65536 + 37'(x_ff) + 37'(t2_ff) + 37'(t3h_ff) + 37'(prod_ff[29:16]);
   assign dot_sum = 67'(dot1_ff) + 67'(prod_ff);

   // shared multiplier operands
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      unique case (state_ff)
         S_X_I: begin
            mul_a = 33'(om_ff);
            mul_b = 33'(dt_ff);
         end
         S_X2_I: begin
            mul_a = 33'(x_ff);
            mul_b = 33'(x_ff);
         end
         S_X3_I: begin
            mul_a = 33'(x2_ff);
            mul_b = 33'(x_ff);
         end
         S_X3_C: begin
            mul_a = 33'(C_048);
            mul_b = 33'(x2_ff);
         end
         S_T2_C: begin
            mul_a = 33'(C_0235);
            mul_b = 33'(x3_ff[36:16]);
         end
         S_T3H_C: begin
            mul_a = 33'(C_0235);
            mul_b = 33'(x3_ff[15:0]);
         end
         S_CH: begin
            mul_a = 33'(speed_cap_ff);
            mul_b = 33'(st_ff);
         end
         S_MC_C: begin
            mul_a = abs_chx;
            mul_b = abs_chx;
         end
         S_SQX_C: begin
            mul_a = abs_chy;
            mul_b = abs_chy;
         end
         S_SQY_C: begin
            mul_a = 33'(mc_ff);
            mul_b = 33'(mc_ff);
         end
         S_W_SQ: begin
            mul_a = abs_chx;
            mul_b = 33'(mc_ff);
         end
         S_W_SCX: begin
            mul_a = abs_chy;
            mul_b = 33'(mc_ff);
         end
         S_TT: begin
            mul_a = 33'(om_ff);
            mul_b = 33'(chx_ff);
         end
         S_A_X: begin
            mul_a = 33'(om_ff);
            mul_b = 33'(chy_ff);
         end
         S_A_Y: begin
            mul_a = 33'(ax_ff);
            mul_b = 33'(dt_ff);
         end
         S_TM_X: begin
            mul_a = 33'(ay_ff);
            mul_b = 33'(dt_ff);
         end
         S_TM_Y: begin
            mul_a = 33'(om_ff);
            mul_b = 33'(tmx_ff);
         end
         S_B_X: begin
            mul_a = 33'(om_ff);
            mul_b = 33'(tmy_ff);
         end
         S_B_Y: begin
            mul_a = 33'(bx_ff);
            mul_b = 33'(e_ff);
         end
         S_V_X: begin
            mul_a = 33'(by_ff);
            mul_b = 33'(e_ff);
         end
         S_V_Y: begin
            mul_a = 33'(add_sat(chx_ff, tmx_ff));
            mul_b = 33'(e_ff);
         end
         S_O_X: begin
            mul_a = 33'(add_sat(chy_ff, tmy_ff));
            mul_b = 33'(e_ff);
         end
         S_O_Y: begin
            mul_a = 33'(tx_ff) - 33'(cx_ff);
            mul_b = 33'(ox_ff) - 33'(tx_ff);
         end
         S_D1: begin
            mul_a = 33'(ty_ff) - 33'(cy_ff);
            mul_b = 33'(oy_ff) - 33'(ty_ff);
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      prod_ff <= mul_a * mul_b;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         rsp_valid_ff   <= 1'b0;
         vel_x_ff       <= '0;
         vel_y_ff       <= '0;
         smooth_time_ff <= SMOOTH_TIME_RESET;
         speed_cap_ff   <= SPEED_UNLIMITED;
         div_start_ff   <= 1'b0;
         sqrt_start_ff  <= 1'b0;
      end else begin
         div_start_ff  <= 1'b0;
         sqrt_start_ff <= 1'b0;

         if (csr_we) begin
            unique case (csr_index)
               REG_SMOOTH_TIME: smooth_time_ff <= csr_wdata;
               REG_SPEED_CAP:   speed_cap_ff   <= csr_wdata;
               default:         speed_cap_ff   <= speed_cap_ff;
            endcase
         end

         if (rsp_valid_ff && rsp_ch.ready && (state_ff != S_DONE)) begin
            rsp_valid_ff <= 1'b0;
         end

         unique case (state_ff)
            S_IDLE: begin
               if (req_ch.valid) begin
                  cx_ff        <= req_ch.current_x;
                  cy_ff        <= req_ch.current_y;
                  tx_ff        <= req_ch.target_x;
                  ty_ff        <= req_ch.target_y;
                  dt_ff        <= req_ch.step_time;
                  st_ff        <= st_in;
                  div_num_ff   <= 64'h2_0000_0000;
                  div_den_ff   <= 33'(st_in);
                  div_start_ff <= 1'b1;
                  state_ff     <= S_W_OM;
               end
            end
            S_W_OM: begin
               if (div_done) begin
                  om_ff    <= div_quo[30:0];
                  state_ff <= S_X_I;
               end
            end
            S_X_I: state_ff <= S_X_C;
            S_X_C: begin
               // large x drives the decay term to zero
               ez_ff    <= |prod_ff[47:39];
               x_ff     <= prod_ff[38:16];
               state_ff <= S_X2_I;
            end
            S_X2_I: state_ff <= S_X2_C;
            S_X2_C: begin
               x2_ff    <= prod_ff[45:16];
               state_ff <= S_X3_I;
            end
            S_X3_I: state_ff <= S_X3_C;
            S_X3_C: begin
               x3_ff    <= prod_ff[52:16];
               state_ff <= S_T2_C;
            end
            S_T2_C: begin
               t2_ff    <= prod_ff[44:16];
               state_ff <= S_T3H_C;
            end
            S_T3H_C: begin
               t3h_ff   <= prod_ff[34:0];
               state_ff <= S_T3L_C;
            end
            S_T3L_C: begin
               if (ez_ff || (d_sum > 37'h1_0000_0000)) begin
                  e_ff     <= '0;
                  state_ff <= S_CH;
               end else begin
                  div_num_ff   <= 64'h1_0000_0000;
                  div_den_ff   <= d_sum[32:0];
                  div_start_ff <= 1'b1;
                  state_ff     <= S_W_E;
               end
            end
            S_W_E: begin
               if (div_done) begin
                  e_ff     <= div_quo[16:0];
                  state_ff <= S_CH;
               end
            end
            S_CH: begin
               chx_ff   <= sub_sat(cx_ff, tx_ff);
               chy_ff   <= sub_sat(cy_ff, ty_ff);
               state_ff <= (speed_cap_ff == SPEED_UNLIMITED) ? S_TT : S_MC_C;
            end
            S_MC_C: begin
               mc_ff    <= (|prod_ff[61:47]) ? SPEED_UNLIMITED : prod_ff[46:16];
               state_ff <= S_SQX_C;
            end
            S_SQX_C: begin
               sq_ff    <= prod_ff[63:0];
               state_ff <= S_SQY_C;
            end
            S_SQY_C: begin
               sq_ff    <= sq_ff + prod_ff[63:0];
               state_ff <= S_CMP;
            end
            S_CMP: begin
               if (sq_ff > prod_ff[63:0]) begin
                  sqrt_start_ff <= 1'b1;
                  state_ff      <= S_W_SQ;
               end else begin
                  state_ff <= S_TT;
               end
            end
            S_W_SQ: begin
               if (sqrt_done) begin
                  g_ff     <= sqrt_root;
                  state_ff <= S_SCX_D;
               end
            end
            S_SCX_D: begin
               div_num_ff   <= prod_ff[63:0];
               div_den_ff   <= {1'b0, g_ff};
               div_start_ff <= 1'b1;
               state_ff     <= S_W_SCX;
            end
            S_W_SCX: begin
               if (div_done) begin
                  chx_ff   <= chx_ff[31] ? -32'(div_quo[30:0]) : 32'(div_quo[30:0]);
                  state_ff <= S_SCY_D;
               end
            end
            S_SCY_D: begin
               div_num_ff   <= prod_ff[63:0];
               div_den_ff   <= {1'b0, g_ff};
               div_start_ff <= 1'b1;
               state_ff     <= S_W_SCY;
            end
            S_W_SCY: begin
               if (div_done) begin
                  chy_ff   <= chy_ff[31] ? -32'(div_quo[30:0]) : 32'(div_quo[30:0]);
                  state_ff <= S_TT;
               end
            end
            S_TT: begin
               ttx_ff   <= sub_sat(cx_ff, chx_ff);
               tty_ff   <= sub_sat(cy_ff, chy_ff);
               state_ff <= S_A_X;
            end
            S_A_X: begin
               ax_ff    <= add_sat(vel_x_ff, mul_q16(prod_ff));
               state_ff <= S_A_Y;
            end
            S_A_Y: begin
               ay_ff    <= add_sat(vel_y_ff, mul_q16(prod_ff));
               state_ff <= S_TM_X;
            end
            S_TM_X: begin
               tmx_ff   <= mul_q16(prod_ff);
               state_ff <= S_TM_Y;
            end
            S_TM_Y: begin
               tmy_ff   <= mul_q16(prod_ff);
               state_ff <= S_B_X;
            end
            S_B_X: begin
               bx_ff    <= sub_sat(vel_x_ff, mul_q16(prod_ff));
               state_ff <= S_B_Y;
            end
            S_B_Y: begin
               by_ff    <= sub_sat(vel_y_ff, mul_q16(prod_ff));
               state_ff <= S_V_X;
            end
            S_V_X: begin
               vx_ff    <= mul_q16(prod_ff);
               state_ff <= S_V_Y;
            end
            S_V_Y: begin
               vy_ff    <= mul_q16(prod_ff);
               state_ff <= S_O_X;
            end
            S_O_X: begin
               ox_ff    <= add_sat(ttx_ff, mul_q16(prod_ff));
               state_ff <= S_O_Y;
            end
            S_O_Y: begin
               oy_ff    <= add_sat(tty_ff, mul_q16(prod_ff));
               state_ff <= S_D1;
            end
            S_D1: begin
               dot1_ff  <= prod_ff;
               state_ff <= S_D2;
            end
            S_D2: begin
               snap_ff  <= (dot_sum > 67'sd0);
               state_ff <= S_DONE;
            end
            S_DONE: begin
               if (!rsp_valid_ff || rsp_ch.ready) begin
                  next_x_ff    <= snap_ff ? tx_ff : ox_ff;
                  next_y_ff    <= snap_ff ? ty_ff : oy_ff;
                  speed_x_ff   <= snap_ff ? '0 : vx_ff;
                  speed_y_ff   <= snap_ff ? '0 : vy_ff;
                  vel_x_ff     <= snap_ff ? '0 : vx_ff;
                  vel_y_ff     <= snap_ff ? '0 : vy_ff;
                  snapped_ff   <= snap_ff;
                  rsp_valid_ff <= 1'b1;
                  state_ff     <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

endmodule

// ===== verif/tb_vector2_smooth_damp_follower.sv =====
// Self-checking testbench for the smooth damp follower: directed table, then random phases.
`timescale 1ns / 1ps

module tb_vector2_smooth_damp_follower;
   import sdf_pkg::*;

   localparam int STALL_LIMIT = 5000;
   localparam int HOLD_CYCLES = 600;
   localparam int TAIL_CYCLES = 300;
   localparam int PHASE_ITEMS = 260;

   typedef struct {
      word_type  cx, cy, tx, ty;
      dtime_type dt;
   } pos_request_type;

   typedef struct {
      word_type nx, ny, vx, vy;
      logic     snap;
   } pos_result_type;

   typedef struct {
      ureg_type        smooth, speed;
      pos_request_type req;
      logic            typed;
      pos_result_type  want;
   } table_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_we = 1'b0;
   regidx_type csr_index = REG_SMOOTH_TIME;
   ureg_type csr_wdata = '0;

   sdf_req_if req_bus();
   sdf_rsp_if rsp_bus();

   vector2_smooth_damp_follower dut (
      .clock(clock), .reset(reset), .csr_we(csr_we), .csr_index(csr_index),
      .csr_wdata(csr_wdata), .req_ch(req_bus), .rsp_ch(rsp_bus)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // model state
   ureg_type cfg_smooth = SMOOTH_TIME_RESET;
   ureg_type cfg_speed = SPEED_UNLIMITED;
   word_type vel_x = '0, vel_y = '0;
   word_type last_nx = '0, last_ny = '0;

   pos_result_type pending_results[$];
   table_row_type directed_rows[$];
   int errors = 0, checked = 0, snaps = 0, limited = 0, sent = 0;
   int idle_cycles = 0;
   int idle_pct = 54;
   bit sender_idle = 0, recv_stall = 0, hold_go = 0;

   function automatic word_type clip32(longint v);
      if (v > 64'sd2147483647) return 32'sh7FFF_FFFF;
      if (v < -64'sd2147483648) return 32'sh8000_0000;
      return word_type'(v[31:0]);
   endfunction

   function automatic word_type qmul(word_type a, word_type b);
      longint p;
      p = longint'(a) * longint'(b);
      if (p < 0) return clip32(-((-p) >>> 16));
      return clip32(p >>> 16);
   endfunction

   function automatic longint unsigned int_sqrt(longint unsigned n);
      longint unsigned res, bitv;
      res = 0;
      bitv = 64'd1 << 62;
      while (bitv > n) bitv = bitv >> 2;
      while (bitv != 0) begin
         if (n >= res + bitv) begin
            n = n - (res + bitv);
            res = (res >> 1) + bitv;
         end else begin
            res = res >> 1;
         end
         bitv = bitv >> 2;
      end
      return res;
   endfunction

   function automatic longint unsigned absval(longint v);
      return v < 0 ? longint'(-v) : v;
   endfunction

   function automatic word_type rescale(word_type c, longint unsigned m, longint unsigned g);
      longint unsigned q;
      q = (absval(c) * m) / g;
      return c < 0 ? clip32(-longint'(q)) : clip32(longint'(q));
   endfunction

   task automatic follow_step(input pos_request_type r, output pos_result_type o);
      longint unsigned st, omega, x, x2, x3, d, ex, mc, sq, g;
      longint cx, cy, tx, ty;
      word_type chx, chy, ttx, tty, tmx, tmy, vx, vy, ox, oy, om, e;
      logic signed [67:0] dot;
      cx = r.cx; cy = r.cy; tx = r.tx; ty = r.ty;
      st = (cfg_smooth < ST_MIN) ? ST_MIN : cfg_smooth;
      omega = (64'd1 << 33) / st;
      x = (omega * r.dt) >> 16;
      if (x > (64'd1024 << 16)) x = 64'd1024 << 16;
      x2 = (x * x) >> 16;
      x3 = (x2 * x) >> 16;
      d = 65536 + x + ((64'd31457 * x2) >> 16) + ((64'd15401 * x3) >> 16);
      ex = (64'd1 << 32) / d;
      om = word_type'(omega[31:0]);
      e = word_type'(ex[31:0]);
      chx = clip32(cx - tx);
      chy = clip32(cy - ty);
      if (cfg_speed != SPEED_UNLIMITED) begin
         mc = (longint'(cfg_speed) * st) >> 16;
         if (mc > 64'h7FFF_FFFF) mc = 64'h7FFF_FFFF;
         sq = absval(chx) * absval(chx) + absval(chy) * absval(chy);
         if (sq > mc * mc) begin
            g = int_sqrt(sq);
            chx = rescale(chx, mc, g);
            chy = rescale(chy, mc, g);
            limited++;
         end
      end
      ttx = clip32(cx - chx);
      tty = clip32(cy - chy);
      tmx = qmul(clip32(longint'(vel_x) + qmul(om, chx)), word_type'({15'd0, r.dt}));
      tmy = qmul(clip32(longint'(vel_y) + qmul(om, chy)), word_type'({15'd0, r.dt}));
      vx = qmul(clip32(longint'(vel_x) - qmul(om, tmx)), e);
      vy = qmul(clip32(longint'(vel_y) - qmul(om, tmy)), e);
      ox = clip32(longint'(ttx) + qmul(clip32(longint'(chx) + tmx), e));
      oy = clip32(longint'(tty) + qmul(clip32(longint'(chy) + tmy), e));
      dot = $signed(68'(tx - cx)) * $signed(68'(longint'(ox) - tx))
          + $signed(68'(ty - cy)) * $signed(68'(longint'(oy) - ty));
      o.snap = 1'b0;
      if (dot > 0) begin
         ox = r.tx; oy = r.ty; vx = '0; vy = '0;
         o.snap = 1'b1;
         snaps++;
      end
      vel_x = vx; vel_y = vy;
      last_nx = ox; last_ny = oy;
      o.nx = ox; o.ny = oy; o.vx = vx; o.vy = vy;
   endtask

   task automatic report_mismatch(string field, word_type got, word_type want);
      $display("MISMATCH result %0d %s: got %h want %h", checked, field, got, want);
      errors++;
   endtask

   // response side: ready control with random stalls and a long hold-off on demand
   initial begin
      rsp_bus.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_go) begin
            rsp_bus.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_go = 0;
         end
         rsp_bus.ready <= !(recv_stall && $urandom_range(99) < idle_pct);
      end
   end

   always @(posedge clock) begin
      pos_result_type w;
      if (!reset) begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (pending_results.size() == 0) begin
               report_mismatch("unexpected next_x", rsp_bus.next_x, '0);
            end else begin
               w = pending_results.pop_front();
               if (rsp_bus.next_x !== w.nx) report_mismatch("next_x", rsp_bus.next_x, w.nx);
               if (rsp_bus.next_y !== w.ny) report_mismatch("next_y", rsp_bus.next_y, w.ny);
               if (rsp_bus.speed_x !== w.vx) report_mismatch("speed_x", rsp_bus.speed_x, w.vx);
               if (rsp_bus.speed_y !== w.vy) report_mismatch("speed_y", rsp_bus.speed_y, w.vy);
               if (rsp_bus.snapped !== w.snap)
                  report_mismatch("snapped", word_type'(rsp_bus.snapped), word_type'(w.snap));
               checked++;
            end
         end
         if ((rsp_bus.valid && rsp_bus.ready) || (req_bus.valid && req_bus.ready)) begin
            idle_cycles = 0;
         end else begin
            idle_cycles++;
            if (idle_cycles >= STALL_LIMIT) begin
               $display("watchdog: no handshake for %0d cycles", STALL_LIMIT);
               $display("end of test: mismatches");
               $finish;
            end
         end
      end
   end

   // offers one request; the prediction is taken when it is accepted
   task automatic send_request(input pos_request_type r, input logic typed,
                               input pos_result_type want);
      pos_result_type o;
      int gap;
      gap = 0;
      while (sender_idle && $urandom_range(99) < idle_pct) gap++;
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.current_x <= r.cx;
      req_bus.current_y <= r.cy;
      req_bus.target_x <= r.tx;
      req_bus.target_y <= r.ty;
      req_bus.step_time <= r.dt;
      do @(posedge clock); while (!req_bus.ready);
      follow_step(r, o);
      pending_results.push_back(typed ? want : o);
      sent++;
   endtask

   task automatic drain;
      req_bus.valid <= 1'b0;
      do @(posedge clock); while (pending_results.size() != 0);
   endtask

   task automatic write_config(input ureg_type smooth, input ureg_type speed);
      drain();
      csr_we <= 1'b1;
      csr_index <= REG_SMOOTH_TIME;
      csr_wdata <= smooth;
      @(posedge clock);
      csr_index <= REG_SPEED_CAP;
      csr_wdata <= speed;
      @(posedge clock);
      csr_we <= 1'b0;
      cfg_smooth = smooth;
      cfg_speed = speed;
   endtask

   task automatic add_row(input ureg_type smooth, input ureg_type speed, input word_type cx,
                          input word_type cy, input word_type tx, input word_type ty,
                          input dtime_type dt, input logic typed);
      table_row_type row;
      row.smooth = smooth; row.speed = speed;
      row.req.cx = cx; row.req.cy = cy; row.req.tx = tx; row.req.ty = ty; row.req.dt = dt;
      row.typed = typed;
      row.want.nx = cx; row.want.ny = cy; row.want.vx = '0; row.want.vy = '0;
      row.want.snap = 1'b0;
      directed_rows.push_back(row);
   endtask

   function automatic word_type rand_word(bit wide);
      if (wide) return word_type'($urandom);
      return word_type'($signed($urandom_range(0, 2 * 655360)) - 655360);
   endfunction

   task automatic random_phase(input int count);
      pos_request_type r;
      pos_result_type none;
      word_type gx, gy;
      none = '{default: '0};
      gx = rand_word($urandom_range(3) == 0);
      gy = rand_word($urandom_range(3) == 0);
      for (int i = 0; i < count; i++) begin
         if ($urandom_range(19) == 0) begin
            gx = rand_word($urandom_range(3) == 0);
            gy = rand_word($urandom_range(3) == 0);
         end
         if ($urandom_range(99) < 72) begin
            r.cx = last_nx; r.cy = last_ny; r.tx = gx; r.ty = gy;
            case ($urandom_range(9))
               0: r.dt = '0;
               1: r.dt = dtime_type'($urandom_range(0, 131071));
               default: r.dt = dtime_type'($urandom_range(1, 4369));
            endcase
         end else begin
            r.cx = $urandom; r.cy = $urandom; r.tx = $urandom; r.ty = $urandom;
            r.dt = dtime_type'($urandom_range(0, 131071));
         end
         send_request(r, 1'b0, none);
      end
   endtask

   initial begin
      ureg_type cur_smooth, cur_speed;
      req_bus.valid = 1'b0;
      req_bus.current_x = '0;
      req_bus.current_y = '0;
      req_bus.target_x = '0;
      req_bus.target_y = '0;
      req_bus.step_time = '0;

      add_row(SMOOTH_TIME_RESET, SPEED_UNLIMITED, 0, 0, 0, 0, 17'd0, 1'b1);
      add_row(SMOOTH_TIME_RESET, SPEED_UNLIMITED, 32'sh8000_0000, 32'sh7FFF_FFFF,
              32'sh7FFF_FFFF, 32'sh8000_0000, 17'd65536, 1'b0);
      add_row(SMOOTH_TIME_RESET, SPEED_UNLIMITED, 32'sh7FFF_FFFF, 32'sh8000_0000,
              32'sh8000_0000, 32'sh7FFF_FFFF, 17'h1FFFF, 1'b0);
      add_row(SMOOTH_TIME_RESET, SPEED_UNLIMITED, 100 << 16, -(50 << 16), 0, 0, 17'd0, 1'b0);
      add_row(SMOOTH_TIME_RESET, SPEED_UNLIMITED, 100 << 16, -(50 << 16), 0, 0, 17'd1, 1'b0);
      add_row(SMOOTH_TIME_RESET, SPEED_UNLIMITED, 90 << 16, -(45 << 16), 0, 0, 17'd65536,
              1'b0);
      add_row(SMOOTH_TIME_RESET, SPEED_UNLIMITED, 10 << 16, -(5 << 16), 0, 0, 17'd65536,
              1'b0);
      add_row(SMOOTH_TIME_RESET, SPEED_UNLIMITED, -(1 << 16), 1 << 16, 0, 0, 17'd32768,
              1'b0);
      add_row(31'd0, 31'd0, 5 << 16, 7 << 16, -(3 << 16), 2 << 16, 17'd1092, 1'b0);
      add_row(31'd0, 31'd0, 32'sh8000_0000, 32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF,
              17'd65536, 1'b0);
      add_row(31'd0, 31'd0, 0, 0, 0, 0, 17'h1FFFF, 1'b0);
      add_row(31'd7, 31'd65536, 1000 << 16, 0, 0, 0, 17'd1092, 1'b0);
      add_row(31'd7, 31'd65536, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh8000_0000,
              32'sh8000_0000, 17'd1, 1'b0);
      add_row(31'd7, 31'd65536, 3 << 16, -(4 << 16), 0, 0, 17'd0, 1'b0);
      add_row(31'h7FFF_FFFF, 31'h7FFF_FFFE, 32'sh8000_0000, 0, 32'sh7FFF_FFFF, 0,
              17'd65536, 1'b0);
      add_row(31'h7FFF_FFFF, 31'h7FFF_FFFE, 12345, -6789, 777, 888, 17'h1FFFF, 1'b0);
      add_row(31'd6554, 31'd131072, 40 << 16, 30 << 16, 0, 0, 17'd4369, 1'b0);
      add_row(31'd6554, 31'd131072, 40 << 16, 30 << 16, 0, 0, 17'd4369, 1'b0);
      add_row(31'd6554, 31'd131072, -(40 << 16), 30 << 16, 1 << 16, -(1 << 16), 17'd65536,
              1'b0);

      repeat (3) @(posedge clock);
      reset <= 1'b0;
      cur_smooth = SMOOTH_TIME_RESET;
      cur_speed = SPEED_UNLIMITED;
      write_config(cur_smooth, cur_speed);

      foreach (directed_rows[i]) begin
         if (directed_rows[i].smooth != cur_smooth || directed_rows[i].speed != cur_speed) begin
            cur_smooth = directed_rows[i].smooth;
            cur_speed = directed_rows[i].speed;
            write_config(cur_smooth, cur_speed);
         end
         send_request(directed_rows[i].req, directed_rows[i].typed, directed_rows[i].want);
      end

      for (int ph = 0; ph < 5; ph++) begin
         case (ph)
            0: write_config(SMOOTH_TIME_RESET, SPEED_UNLIMITED);
            1: write_config(31'd0, 31'd0);
            2: write_config(31'd7, 31'd196608);
            3: write_config(31'h7FFF_FFFF, 31'h7FFF_FFFE);
            default: write_config(ureg_type'($urandom_range(0, 262144)), ureg_type'($urandom));
         endcase
         sender_idle = (ph % 4 == 1) || (ph % 4 == 3);
         recv_stall = (ph % 4 == 2) || (ph % 4 == 3);
         idle_pct = (ph % 4 == 3) ? 27 : 54;
         if (ph == 1) hold_go = 1;
         random_phase(PHASE_ITEMS / 2);
         if (ph == 2) drain();
         random_phase(PHASE_ITEMS / 2);
      end
      write_config(ureg_type'($urandom), ureg_type'($urandom));
      random_phase(40);

      drain();
      repeat (TAIL_CYCLES) @(posedge clock);
      $display("%0d requests sent, %0d results checked, %0d snapped to target", sent, checked,
               snaps);
      $display("%0d offsets clipped by the speed cap; smooth time and cap swept to extremes",
               limited);
      if (errors == 0 && pending_results.size() == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule
